### sv/trial_division_prime_test_core_macros.svh
// ----------------------------------------------------------------------------
// Trial division prime test: assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_MACROS_SVH

// same-cycle implication
`define TDP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tdp_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test: package
// Widths, sequencer states and the request/response types of the remainder unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdp_pkg;

  localparam int NUMBER_WIDTH = 16;
  // divisor only runs while its square stays within the number
  localparam int DIV_WIDTH    = (NUMBER_WIDTH + 1) / 2 + 1;
  localparam int SQ_WIDTH     = NUMBER_WIDTH + 1;
  localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } tdp_state_t;

  typedef struct packed {
    logic start;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

### sv/tdp_rem_unit.sv
// ----------------------------------------------------------------------------
// Trial division prime test: remainder unit
// Restoring bit-serial remainder, one dividend bit per cycle through a single
// compare-and-subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdp_rem_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tdp_pkg::rem_req_t                   req,
  input  logic [tdp_pkg::NUMBER_WIDTH-1:0]    dividend,
  input  logic [tdp_pkg::DIV_WIDTH-1:0]       divisor,
  output tdp_pkg::rem_rsp_t                   rsp
);

  import tdp_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_WIDTH-1:0]    cnt_r, cnt_nxt;
  logic [DIV_WIDTH-1:0]    rem_r, rem_nxt;
  logic [NUMBER_WIDTH-1:0] sh_r, sh_nxt;

  logic [DIV_WIDTH:0]      trial;
  logic [DIV_WIDTH:0]      diff;

  always_comb begin
    trial = {rem_r, sh_r[NUMBER_WIDTH-1]};
    diff  = trial - {1'b0, divisor};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_WIDTH'(NUMBER_WIDTH - 1);
      rem_nxt  = '0;
      sh_nxt   = dividend;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, divisor}) ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
      sh_nxt  = {sh_r[NUMBER_WIDTH-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.zero = (rem_r == '0);

endmodule

### sv/trial_division_prime_test_core.sv
// ----------------------------------------------------------------------------
// Trial division prime test core
// Tests one unsigned number per transaction for primality by trial division.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   in      | in_valid in_ready in_candidate | to core
//   out     | out_valid out_ready out_is_prime | from core
//
// Each divisor from 2 upward takes one full pass through the shared
// remainder unit; the search ends once divisor squared exceeds the number.
// Values below 2 go straight from idle to done. in_ready is low from
// acceptance until the result transaction completes. No state survives
// between transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "trial_division_prime_test_core_macros.svh"

module trial_division_prime_test_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tdp_pkg::NUMBER_WIDTH-1:0] in_candidate,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_is_prime
);

  import tdp_pkg::*;

  tdp_state_t              state_r, state_nxt;
  logic [NUMBER_WIDTH-1:0] n_r, n_nxt;
  logic [DIV_WIDTH-1:0]    d_r, d_nxt;
  logic [SQ_WIDTH-1:0]     sq_r, sq_nxt;
  logic                    prime_r, prime_nxt;

  rem_req_t req;
  rem_rsp_t rsp;

  logic in_fire;
  logic past_bound;
  logic small_num;

  assign in_fire    = in_valid && in_ready;
  assign past_bound = (sq_r > {1'b0, n_r});
  assign small_num  = (in_candidate < NUMBER_WIDTH'(2));

  tdp_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .dividend (n_r),
    .divisor  (d_r),
    .rsp      (rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = small_num ? ST_DONE : ST_CHECK;
      ST_CHECK: state_nxt = past_bound ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (rsp.done) state_nxt = rsp.zero ? ST_DONE : ST_CHECK;
      end
      ST_DONE:  if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_DONE);
    req.start = (state_r == ST_CHECK) && !past_bound;
  end

  // datapath
  always_comb begin
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    prime_nxt = prime_r;
    if (in_fire) begin
      n_nxt     = in_candidate;
      d_nxt     = DIV_WIDTH'(2);
      sq_nxt    = SQ_WIDTH'(4);
      prime_nxt = 1'b0;
    end else if ((state_r == ST_CHECK) && past_bound) begin
      prime_nxt = 1'b1;
    end else if ((state_r == ST_DIV) && rsp.done) begin
      if (rsp.zero) begin
        prime_nxt = 1'b0;
      end else begin
        // (d+1)^2 = d^2 + 2d + 1
        d_nxt  = d_r + 1'b1;
        sq_nxt = sq_r + SQ_WIDTH'({d_r, 1'b1});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    prime_r <= prime_nxt;
  end

  assign out_is_prime = prime_r;

  `TDP_ASSERT_NEXT(a_small_not_prime, in_fire && small_num, out_valid && !out_is_prime, "0 or 1 not rejected")
  `TDP_ASSERT_NEXT(a_bound_prime, (state_r == ST_CHECK) && past_bound, out_valid && out_is_prime, "search end not reported prime")
  `TDP_ASSERT_NEXT(a_factor_found, (state_r == ST_DIV) && rsp.done && rsp.zero, out_valid && !out_is_prime, "factor not reported")
  `TDP_ASSERT_SAME(a_div_in_bound, state_r == ST_DIV, sq_r <= {1'b0, n_r}, "divisor beyond square-root bound")

endmodule
